>>> src/lcfc_pkg.sv
// Shared types and constants for the line credit flow control block.
`default_nettype none

package lcfc_pkg;

  localparam logic [3:0] EV_ABSORB       = 4'd0;
  localparam logic [3:0] EV_SENT         = 4'd1;
  localparam logic [3:0] EV_WAIT         = 4'd2;
  localparam logic [3:0] EV_OK           = 4'd3;
  localparam logic [3:0] EV_ERROR        = 4'd4;
  localparam logic [3:0] EV_OTHER        = 4'd5;
  localparam logic [3:0] EV_NONE_PENDING = 4'd6;
  localparam logic [3:0] EV_TOO_LONG     = 4'd7;
  localparam logic [3:0] EV_TOO_BIG      = 4'd8;

  localparam logic KIND_OFFER = 1'b0;
  localparam logic KIND_RX    = 1'b1;

  localparam logic [1:0] CLS_OTHER = 2'd0;
  localparam logic [1:0] CLS_OK    = 2'd1;
  localparam logic [1:0] CLS_ERR   = 2'd2;
  localparam logic [1:0] CLS_LONG  = 2'd3;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_O     = 8'h6F;
  localparam logic [7:0] CH_K     = 8'h6B;

  localparam int OK_LEN  = 2;
  localparam int ERR_LEN = 5;

  localparam logic [7:0] BUFFER_RESET = 8'd128;

  typedef struct packed {
    logic       line_end;
    logic [1:0] cls;
  } rx_class_t;

  function automatic logic [7:0] err_char(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0: ch = 8'h65;
      3'd1: ch = 8'h72;
      3'd2: ch = 8'h72;
      3'd3: ch = 8'h6F;
      3'd4: ch = 8'h72;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

>>> src/line_credit_flow_control.sv
// Top level of the line credit flow control block with output register.
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+-----------------------------------
//  in       | input     | in_valid / in_stall     | kind, line_length, rx_byte
//  out      | output    | out_valid / out_stall   | event_res, line_index, credits
//  cfg      | input     | cfg_wr_en               | cfg_wr_data (buffer_bytes)
//
// One request per clock unless in_stall is high; each result appears in the cycle after
// its request is taken. The FIFO head is read ahead from the pending RAM, with a bypass
// for a push to the entry about to be read, so a pop never waits on the RAM latency.
// Reset is synchronous; no clearing pass is needed, the pending RAM holds no valid bits.
// in_stall rises only while a result waits and out_stall is high.
`default_nettype none

module line_credit_flow_control #(
  parameter int PENDING_DEPTH = 128,
  parameter int RX_LINE_MAX   = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        kind,
  input  wire logic [7:0]  line_length,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [3:0]  event_res,
  output logic      [15:0] line_index,
  output logic      [7:0]  credits
);
  import lcfc_pkg::*;

  logic        step_fire;
  logic        offer_fire;
  logic        byte_fire;
  rx_class_t   rx_class;
  logic [3:0]  ev;
  logic [15:0] idx;
  logic [7:0]  credits_next;

  assign in_stall   = out_valid && out_stall;
  assign step_fire  = in_valid && !in_stall;
  assign offer_fire = step_fire && (kind == KIND_OFFER);
  assign byte_fire  = step_fire && (kind == KIND_RX);

  lcfc_rx_parse #(
    .RX_LINE_MAX(RX_LINE_MAX)
  ) u_rx_parse (
    .clk      (clk),
    .rst      (rst),
    .byte_fire(byte_fire),
    .rx_byte  (rx_byte),
    .rx_class (rx_class)
  );

  lcfc_credit_ctrl #(
    .PENDING_DEPTH(PENDING_DEPTH)
  ) u_credit_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .offer_fire  (offer_fire),
    .line_length (line_length),
    .rx_class    (rx_class),
    .ev          (ev),
    .idx         (idx),
    .credits_next(credits_next)
  );

  always_ff @(posedge clk) begin
    if (step_fire) begin
      event_res  <= ev;
      line_index <= idx;
      credits    <= credits_next;
    end
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

>>> src/lcfc_ram.sv
// Generic single write port RAM with registered read.
`default_nettype none

module lcfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

>>> src/lcfc_rx_parse.sv
// Response line assembler and ok/error line classifier.
`default_nettype none

module lcfc_rx_parse #(
  parameter int RX_LINE_MAX = 256
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       byte_fire,
  input  wire logic [7:0] rx_byte,
  output lcfc_pkg::rx_class_t rx_class
);
  import lcfc_pkg::*;

  localparam int LW = $clog2(RX_LINE_MAX + 1);

  logic [LW-1:0] rx_len;
  logic [LW-1:0] rx_len_next;
  logic          flag_ok;
  logic          flag_ok_next;
  logic          flag_err;
  logic          flag_err_next;
  logic          flag_colon;
  logic          flag_colon_next;
  logic          printable;
  logic          is_nl;
  logic          at_max;

  always_comb begin
    printable = (rx_byte >= CH_SPACE) && (rx_byte <= CH_TILDE);
    is_nl     = rx_byte == CH_NL;
    at_max    = rx_len == LW'(RX_LINE_MAX);

    rx_class.line_end = byte_fire && is_nl;
    if (at_max) begin
      rx_class.cls = CLS_LONG;
    end else if (flag_ok && rx_len == LW'(OK_LEN)) begin
      rx_class.cls = CLS_OK;
    end else if ((flag_err && rx_len == LW'(ERR_LEN)) || flag_colon) begin
      rx_class.cls = CLS_ERR;
    end else begin
      rx_class.cls = CLS_OTHER;
    end

    rx_len_next     = rx_len;
    flag_ok_next    = flag_ok;
    flag_err_next   = flag_err;
    flag_colon_next = flag_colon;
    if (byte_fire) begin
      if (is_nl) begin
        rx_len_next     = '0;
        flag_ok_next    = 1'b1;
        flag_err_next   = 1'b1;
        flag_colon_next = 1'b0;
      end else if (printable && !at_max) begin
        if (!((rx_len == LW'(0) && rx_byte == CH_O) ||
              (rx_len == LW'(1) && rx_byte == CH_K))) begin
          flag_ok_next = 1'b0;
        end
        if (rx_len < LW'(ERR_LEN)) begin
          if (rx_byte != err_char(rx_len[2:0])) begin
            flag_err_next = 1'b0;
          end
        end else if (rx_len == LW'(ERR_LEN)) begin
          if (flag_err && rx_byte == CH_COLON) begin
            flag_colon_next = 1'b1;
          end
          flag_err_next = 1'b0;
        end
        rx_len_next = rx_len + LW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_len     <= '0;
      flag_ok    <= 1'b1;
      flag_err   <= 1'b1;
      flag_colon <= 1'b0;
    end else begin
      rx_len     <= rx_len_next;
      flag_ok    <= flag_ok_next;
      flag_err   <= flag_err_next;
      flag_colon <= flag_colon_next;
    end
  end

endmodule

`default_nettype wire

>>> src/lcfc_credit_ctrl.sv
// Credit counter and pending length FIFO held in RAM with head read-ahead.
`default_nettype none

module lcfc_credit_ctrl #(
  parameter int PENDING_DEPTH = 128
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data,
  input  wire logic       offer_fire,
  input  wire logic [7:0] line_length,
  input  wire lcfc_pkg::rx_class_t rx_class,
  output logic      [3:0]  ev,
  output logic      [15:0] idx,
  output logic      [7:0]  credits_next
);
  import lcfc_pkg::*;

  localparam int PW = $clog2(PENDING_DEPTH);
  localparam int CW = $clog2(PENDING_DEPTH + 1);

  logic [7:0]    buffer_bytes;
  logic [7:0]    free_credits;
  logic [PW-1:0] fifo_head;
  logic [PW-1:0] fifo_head_next;
  logic [PW-1:0] fifo_tail;
  logic [PW-1:0] fifo_tail_next;
  logic [CW-1:0] pending_count;
  logic [CW-1:0] pending_count_next;
  logic [15:0]   sent_count;
  logic [15:0]   sent_count_next;
  logic [15:0]   acked_count;
  logic [15:0]   acked_count_next;
  logic          ram_we;
  logic [PW-1:0] rd_addr;
  logic [7:0]    rd_data;
  logic          bypass;
  logic [7:0]    bypass_data;
  logic [7:0]    head_len;
  logic [8:0]    credit_sum;

  assign head_len   = bypass ? bypass_data : rd_data;
  assign credit_sum = {1'b0, free_credits} + {1'b0, head_len};
  assign rd_addr    = rst ? '0 : fifo_head_next;

  always_comb begin
    ev                 = EV_ABSORB;
    idx                = '0;
    credits_next       = free_credits;
    fifo_head_next     = fifo_head;
    fifo_tail_next     = fifo_tail;
    pending_count_next = pending_count;
    sent_count_next    = sent_count;
    acked_count_next   = acked_count;
    ram_we             = 1'b0;
    if (offer_fire) begin
      if (line_length > buffer_bytes) begin
        ev = EV_TOO_BIG;
      end else if (line_length > free_credits ||
                   pending_count == CW'(PENDING_DEPTH)) begin
        ev = EV_WAIT;
      end else begin
        ev                 = EV_SENT;
        credits_next       = free_credits - line_length;
        ram_we             = 1'b1;
        fifo_tail_next     = (fifo_tail == PW'(PENDING_DEPTH - 1)) ? '0
                                                                   : fifo_tail + PW'(1);
        pending_count_next = pending_count + CW'(1);
        idx                = sent_count;
        sent_count_next    = sent_count + 16'd1;
      end
    end else if (rx_class.line_end) begin
      case (rx_class.cls)
        CLS_LONG: ev = EV_TOO_LONG;
        CLS_OK, CLS_ERR: begin
          if (pending_count == '0) begin
            ev = EV_NONE_PENDING;
          end else begin
            ev                 = (rx_class.cls == CLS_OK) ? EV_OK : EV_ERROR;
            credits_next       = credit_sum[8] ? 8'hFF : credit_sum[7:0];
            fifo_head_next     = (fifo_head == PW'(PENDING_DEPTH - 1)) ? '0
                                                                       : fifo_head + PW'(1);
            pending_count_next = pending_count - CW'(1);
            idx                = acked_count;
            acked_count_next   = acked_count + 16'd1;
          end
        end
        default: ev = EV_OTHER;
      endcase
    end
  end

  lcfc_ram #(
    .WIDTH(8),
    .DEPTH(PENDING_DEPTH)
  ) u_pending_ram (
    .clk    (clk),
    .we     (ram_we),
    .wr_addr(fifo_tail),
    .wr_data(line_length),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    bypass_data <= line_length;
    if (rst) begin
      buffer_bytes  <= BUFFER_RESET;
      free_credits  <= BUFFER_RESET;
      fifo_head     <= '0;
      fifo_tail     <= '0;
      pending_count <= '0;
      sent_count    <= '0;
      acked_count   <= '0;
      bypass        <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        buffer_bytes <= cfg_wr_data;
      end
      free_credits  <= credits_next;
      fifo_head     <= fifo_head_next;
      fifo_tail     <= fifo_tail_next;
      pending_count <= pending_count_next;
      sent_count    <= sent_count_next;
      acked_count   <= acked_count_next;
      bypass        <= ram_we && (fifo_tail == fifo_head_next);
    end
  end

endmodule

`default_nettype wire

>>> test/tb_line_credit_flow_control.sv
// Testbench for line_credit_flow_control: directed rows, then random traffic vs a predictor.
`default_nettype none

module tb_line_credit_flow_control;
  timeunit 1ns;
  timeprecision 1ps;

  import lcfc_pkg::*;

  localparam int PEND_DEPTH = 128;
  localparam int RX_MAX = 256;
  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASE_ITEMS = 140;
  localparam logic [15:0] OK_TEXT = "ok";
  localparam logic [39:0] ERR_TEXT = "error";

  typedef struct packed {
    logic [3:0]  ev;
    logic [15:0] idx;
    logic [7:0]  cr;
  } line_result_t;

  typedef struct {
    logic         k;
    logic [7:0]   len;
    logic [7:0]   ch;
    bit           pinned;
    line_result_t want;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [7:0]  cfg_wr_data;
  logic        in_valid;
  logic        in_stall;
  logic        kind;
  logic [7:0]  line_length;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  event_res;
  logic [15:0] line_index;
  logic [7:0]  credits;

  line_credit_flow_control #(
    .PENDING_DEPTH(PEND_DEPTH),
    .RX_LINE_MAX(RX_MAX)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .kind(kind),
    .line_length(line_length),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .event_res(event_res),
    .line_index(line_index),
    .credits(credits)
  );

  // predictor state
  logic [7:0]  buf_size;
  logic [7:0]  free_cr;
  logic [7:0]  pend_len [PEND_DEPTH];
  int          head;
  int          tail;
  int          pend_count;
  logic [15:0] sent_no;
  logic [15:0] ack_no;
  int          rx_len;
  bit          ok_open;
  bit          err_open;
  bit          err_colon;

  line_result_t expected_results[$];
  stim_row_t    directed_rows[$];
  string        near_miss[10] = '{"o", "k", "err", "erro", "okk", "Ok", "errors", "error;",
                                  "ok:", "xerror:"};
  int           failures;
  int           items_sent;
  int           cycles;
  int           hold_left;
  bit           idle_on;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic line_result_t pop_pending(input logic [3:0] ev);
    line_result_t r;
    int sum;
    r = '{ev: EV_NONE_PENDING, idx: 16'd0, cr: 8'd0};
    if (pend_count != 0) begin
      sum = int'(free_cr) + int'(pend_len[head]);
      free_cr = (sum > 255) ? 8'd255 : sum[7:0];
      head = (head + 1) % PEND_DEPTH;
      pend_count--;
      r.ev = ev;
      r.idx = ack_no;
      ack_no++;
    end
    return r;
  endfunction

  function automatic line_result_t predict_response(input logic k, input logic [7:0] len,
                                                     input logic [7:0] ch);
    line_result_t r;
    int line_len;
    bit was_ok;
    bit was_err;
    bit was_colon;
    r = '{ev: EV_ABSORB, idx: 16'd0, cr: 8'd0};
    if (k == KIND_OFFER) begin
      if (len > buf_size) begin
        r.ev = EV_TOO_BIG;
      end else if (len > free_cr || pend_count >= PEND_DEPTH) begin
        r.ev = EV_WAIT;
      end else begin
        free_cr = free_cr - len;
        pend_len[tail] = len;
        tail = (tail + 1) % PEND_DEPTH;
        pend_count++;
        r.ev = EV_SENT;
        r.idx = sent_no;
        sent_no++;
      end
    end else if (ch == CH_NL) begin
      line_len = rx_len;
      was_ok = ok_open;
      was_err = err_open;
      was_colon = err_colon;
      rx_len = 0;
      ok_open = 1'b1;
      err_open = 1'b1;
      err_colon = 1'b0;
      if (line_len >= RX_MAX) r.ev = EV_TOO_LONG;
      else if (was_ok && line_len == OK_LEN) r = pop_pending(EV_OK);
      else if ((was_err && line_len == ERR_LEN) || was_colon) r = pop_pending(EV_ERROR);
      else r.ev = EV_OTHER;
    end else if (ch >= CH_SPACE && ch <= CH_TILDE && rx_len < RX_MAX) begin
      if (rx_len >= OK_LEN) ok_open = 1'b0;
      else if (ch != OK_TEXT[8*(OK_LEN-1-rx_len) +: 8]) ok_open = 1'b0;
      if (rx_len < ERR_LEN) begin
        if (ch != ERR_TEXT[8*(ERR_LEN-1-rx_len) +: 8]) err_open = 1'b0;
      end else if (rx_len == ERR_LEN) begin
        if (err_open && ch == CH_COLON) err_colon = 1'b1;
        err_open = 1'b0;
      end
      rx_len++;
    end
    r.cr = free_cr;
    return r;
  endfunction

  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while ((b >= CH_SPACE && b <= CH_TILDE) || b == CH_NL);
    return b;
  endfunction

  task automatic check_result();
    line_result_t want;
    if (expected_results.size() == 0) begin
      failures++;
      $display("%0t: unexpected result, expected none, got ev=%0d idx=%0d cr=%0d", $time,
               event_res, line_index, credits);
    end else begin
      want = expected_results.pop_front();
      if (event_res !== want.ev || line_index !== want.idx || credits !== want.cr) begin
        failures++;
        $display("%0t: mismatch, expected ev=%0d idx=%0d cr=%0d, got ev=%0d idx=%0d cr=%0d",
                 $time, want.ev, want.idx, want.cr, event_res, line_index, credits);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      check_result();
      if (hold_left == 0) hold_left = idle_on ? $urandom_range(0, 10) : 0;
    end else if (hold_left > 0) begin
      hold_left--;
    end
    out_stall <= (hold_left > 0);
  end

  task automatic drive_request(input logic k, input logic [7:0] len, input logic [7:0] ch,
                               input bit pinned, input line_result_t fixed);
    line_result_t predicted;
    int gap;
    gap = idle_on ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    line_length <= len;
    rx_byte <= ch;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = predict_response(k, len, ch);
    expected_results.push_back(pinned ? fixed : predicted);
    items_sent++;
  endtask

  task automatic request_line(input logic [7:0] len);
    drive_request(KIND_OFFER, len, 8'($urandom_range(0, 255)), 1'b0, '0);
  endtask

  task automatic deliver_byte(input logic [7:0] ch);
    drive_request(KIND_RX, 8'($urandom_range(0, 255)), ch, 1'b0, '0);
  endtask

  task automatic deliver_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      if ($urandom_range(0, 19) == 0) deliver_byte(noise_byte());
      deliver_byte(s[i]);
    end
  endtask

  task automatic deliver_response();
    int n;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: deliver_text("ok");
      4, 5: deliver_text("error");
      6: begin
        deliver_text("error:");
        n = $urandom_range(0, 8);
        repeat (n) deliver_byte(8'($urandom_range(CH_SPACE, CH_TILDE)));
      end
      7: deliver_text(near_miss[$urandom_range(0, 9)]);
      8: begin
        n = $urandom_range(1, 10);
        repeat (n) deliver_byte(8'($urandom_range(CH_SPACE, CH_TILDE)));
      end
      default: ;
    endcase
    deliver_byte(CH_NL);
  endtask

  task automatic deliver_long_line(input int n);
    deliver_text("error:");
    repeat (n - 6) deliver_byte(8'($urandom_range(CH_SPACE, CH_TILDE)));
    deliver_byte(CH_NL);
  endtask

  task automatic run_traffic(input int budget);
    int start;
    int pick;
    logic [7:0] len;
    start = items_sent;
    while (items_sent - start < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: len = 8'($urandom_range(1, 32));
          6, 7: len = 8'($urandom_range(1, 255));
          8: len = 8'($urandom_range(1, buf_size));
          default: len = 8'($urandom_range(0, 2));
        endcase
        request_line(len);
      end else if (pick < 90) begin
        deliver_response();
      end else begin
        deliver_byte(($urandom_range(0, 1) == 0) ? noise_byte() : 8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_buffer_size(input logic [7:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    buf_size = v;
  endtask

  task automatic fill_pending_fifo();
    while (pend_count > 0) begin
      deliver_text("ok");
      deliver_byte(CH_NL);
    end
    repeat (PEND_DEPTH / 2) request_line(8'd0);
    repeat (PEND_DEPTH / 2) request_line(8'd1);
    request_line(8'd1);
    request_line(8'd0);
  endtask

  task automatic table_row(input logic k, input logic [7:0] len, input logic [7:0] ch,
                           input bit pinned, input logic [3:0] ev, input logic [15:0] idx,
                           input logic [7:0] cr);
    stim_row_t row;
    row.k = k;
    row.len = len;
    row.ch = ch;
    row.pinned = pinned;
    row.want = '{ev: ev, idx: idx, cr: cr};
    directed_rows.push_back(row);
  endtask

  initial begin
    logic [7:0] setting;
    rst <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= 8'd0;
    in_valid <= 1'b0;
    kind <= KIND_OFFER;
    line_length <= 8'd0;
    rx_byte <= 8'd0;
    items_sent = 0;
    idle_on = 1'b1;
    buf_size = BUFFER_RESET;
    free_cr = BUFFER_RESET;
    head = 0;
    tail = 0;
    pend_count = 0;
    sent_no = '0;
    ack_no = '0;
    rx_len = 0;
    ok_open = 1'b1;
    err_open = 1'b1;
    err_colon = 1'b0;

    table_row(KIND_OFFER, 8'd255, 8'h00, 1, EV_TOO_BIG, 16'd0, 8'd128);
    table_row(KIND_OFFER, 8'd129, 8'h00, 1, EV_TOO_BIG, 16'd0, 8'd128);
    table_row(KIND_RX, 8'd0, CH_O, 1, EV_ABSORB, 16'd0, 8'd128);
    table_row(KIND_RX, 8'd0, CH_K, 1, EV_ABSORB, 16'd0, 8'd128);
    table_row(KIND_RX, 8'd0, CH_NL, 1, EV_NONE_PENDING, 16'd0, 8'd128);
    table_row(KIND_OFFER, 8'd128, 8'h00, 1, EV_SENT, 16'd0, 8'd0);
    table_row(KIND_OFFER, 8'd1, 8'h00, 1, EV_WAIT, 16'd0, 8'd0);
    table_row(KIND_OFFER, 8'd0, 8'h00, 1, EV_SENT, 16'd1, 8'd0);
    table_row(KIND_RX, 8'd0, CH_O, 1, EV_ABSORB, 16'd0, 8'd0);
    table_row(KIND_RX, 8'd0, 8'hFF, 1, EV_ABSORB, 16'd0, 8'd0);
    table_row(KIND_RX, 8'd0, CH_K, 1, EV_ABSORB, 16'd0, 8'd0);
    table_row(KIND_RX, 8'd255, CH_NL, 1, EV_OK, 16'd0, 8'd128);
    table_row(KIND_RX, 8'd0, "e", 0, EV_ABSORB, 16'd0, 8'd0);
    table_row(KIND_RX, 8'd0, "r", 0, EV_ABSORB, 16'd0, 8'd0);
    table_row(KIND_RX, 8'd0, 8'h7F, 0, EV_ABSORB, 16'd0, 8'd0);
    table_row(KIND_RX, 8'd0, "r", 0, EV_ABSORB, 16'd0, 8'd0);
    table_row(KIND_RX, 8'd0, CH_NL, 1, EV_OTHER, 16'd0, 8'd128);
    table_row(KIND_RX, 8'd0, CH_NL, 1, EV_OTHER, 16'd0, 8'd128);
    table_row(KIND_RX, 8'd0, "e", 0, EV_ABSORB, 16'd0, 8'd0);
    table_row(KIND_RX, 8'd0, 8'h00, 0, EV_ABSORB, 16'd0, 8'd0);
    table_row(KIND_RX, 8'd0, "r", 0, EV_ABSORB, 16'd0, 8'd0);
    table_row(KIND_RX, 8'd0, "r", 0, EV_ABSORB, 16'd0, 8'd0);
    table_row(KIND_RX, 8'd0, "o", 0, EV_ABSORB, 16'd0, 8'd0);
    table_row(KIND_RX, 8'd0, "r", 0, EV_ABSORB, 16'd0, 8'd0);
    table_row(KIND_RX, 8'd0, CH_NL, 1, EV_ERROR, 16'd1, 8'd128);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      drive_request(directed_rows[i].k, directed_rows[i].len, directed_rows[i].ch,
                    directed_rows[i].pinned, directed_rows[i].want);
    settle();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0, 3, 7: setting = 8'd255;
        1: setting = 8'd1;
        5: setting = BUFFER_RESET;
        default: setting = 8'($urandom_range(2, 254));
      endcase
      write_buffer_size(setting);
      idle_on = (p % 3 != 1);
      if (p == 3) fill_pending_fifo();
      if (p == 2) begin
        deliver_long_line(RX_MAX - 1);
        deliver_long_line(RX_MAX);
        deliver_long_line(RX_MAX + $urandom_range(1, 20));
      end
      run_traffic(PHASE_ITEMS);
      settle();
    end

    idle_on = 1'b1;
    settle();
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
src/lcfc_pkg.sv
src/lcfc_ram.sv
src/lcfc_rx_parse.sv
src/lcfc_credit_ctrl.sv
src/line_credit_flow_control.sv
test/tb_line_credit_flow_control.sv
